>>> hw/rtl/tte_pkg.sv
// Shared types, constants and codes for the tap tempo estimator.
`default_nettype none

package tte_pkg;

  localparam int TIME_W         = 32;
  localparam int BPM_W          = 10;
  localparam int GAP_W          = 16;
  localparam int STATUS_W       = 3;
  localparam int CFG_IDX_W      = 8;
  localparam int CFG_DATA_W     = 16;
  localparam int RING_DEPTH_DEF = 4;
  localparam int DIV_W          = 4;
  localparam int QUO_W          = TIME_W + 1;
  localparam int DIV_STEPS      = QUO_W;
  localparam int BPM_CALC_W     = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [QUO_W-1:0] TEMPO_NUM = QUO_W'(120000);

  localparam logic [CFG_IDX_W-1:0] REG_BPM_LOW     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BPM_HIGH    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RESTART_GAP = CFG_IDX_W'(3);

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED   = 3'd0,
    ST_TOO_SOON  = 3'd1,
    ST_NEED_MORE = 3'd2,
    ST_OUT_RANGE = 3'd3,
    ST_UPDATED   = 3'd4
  } tte_status_t;

  typedef struct packed {
    logic [BPM_W-1:0] bpm_low;
    logic [BPM_W-1:0] bpm_high;
    logic [GAP_W-1:0] min_gap;
    logic [GAP_W-1:0] restart_gap;
  } tte_cfg_t;

  localparam tte_cfg_t CFG_RESET = '{
    bpm_low:     BPM_W'(40),
    bpm_high:    BPM_W'(300),
    min_gap:     GAP_W'(250),
    restart_gap: GAP_W'(3000)
  };

  typedef struct packed {
    logic              compute;
    tte_status_t       status;
    logic [TIME_W-1:0] span;
    logic [DIV_W-1:0]  divisor;
  } tte_job_t;

endpackage

`default_nettype wire

>>> hw/rtl/tte_ifs.sv
// Handshake channel interfaces for taps, results and register writes.
`default_nettype none

interface tte_in_if;
  import tte_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] tap_time_ms;
  logic              tap_ignored;
  modport source (output valid, output tap_time_ms, output tap_ignored, input ready);
  modport sink (input valid, input tap_time_ms, input tap_ignored, output ready);
endinterface

interface tte_out_if;
  import tte_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] tap_status;
  logic [BPM_W-1:0]    tempo_bpm;
  modport source (output valid, output tap_status, output tempo_bpm, input ready);
  modport sink (input valid, input tap_status, input tempo_bpm, output ready);
endinterface

interface tte_cfg_if;
  import tte_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tap_tempo_estimator_core.sv
// Top level of the tap tempo estimator: register file, front end, queue, back end.
// The front end takes a new tap only once it has pushed the job of the last one into the queue.
// A result leaves once its job has passed the queue and the back end, which waits on the divider.
// Up to two 33-step divisions on the shared divider hold the back end for each tap that needs a tempo.
// Reset (rst_n, synchronous, active low) loads the default limits and empties the ring,
// the queue and the output register; no clearing pass is needed.
`default_nettype none

module tap_tempo_estimator_core #(
  parameter int RING_DEPTH = tte_pkg::RING_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  tte_in_if.sink      in_ch,
  tte_out_if.source   out_ch,
  tte_cfg_if.sink     cfg_ch
);
  import tte_pkg::*;

  tte_cfg_t cfg_r;
  tte_job_t push_job;
  tte_job_t pop_job;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_BPM_LOW:     cfg_r.bpm_low     <= cfg_ch.data[BPM_W-1:0];
        REG_BPM_HIGH:    cfg_r.bpm_high    <= cfg_ch.data[BPM_W-1:0];
        REG_MIN_GAP:     cfg_r.min_gap     <= cfg_ch.data[GAP_W-1:0];
        REG_RESTART_GAP: cfg_r.restart_gap <= cfg_ch.data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  tte_front #(
    .RING_DEPTH (RING_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_ch.valid),
    .in_time  (in_ch.tap_time_ms),
    .in_ign   (in_ch.tap_ignored),
    .in_ready (in_ch.ready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  tte_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  tte_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.tap_status),
    .out_bpm    (out_ch.tempo_bpm)
  );

endmodule

`default_nettype wire

>>> hw/rtl/tte_front.sv
// Front end: accepts taps, classifies them and keeps the tap ring.
`default_nettype none

module tte_front #(
  parameter int RING_DEPTH = tte_pkg::RING_DEPTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  tte_pkg::tte_cfg_t            cfg,
  input  wire                          in_valid,
  input  wire  [tte_pkg::TIME_W-1:0]   in_time,
  input  wire                          in_ign,
  output logic                         in_ready,
  input  wire                          q_full,
  output logic                         q_push,
  output tte_pkg::tte_job_t            q_job
);
  import tte_pkg::*;

  localparam int HEAD_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_CLASS = 4'b0010,
    F_READ  = 4'b0100,
    F_PUSH  = 4'b1000
  } front_state_t;

  front_state_t      state_r;
  logic [TIME_W-1:0] now_r;
  logic              ign_r;
  logic [TIME_W-1:0] prev_r;
  logic [HEAD_W-1:0] head_r;
  logic [CNT_W-1:0]  cnt_r;
  tte_job_t          job_r;
  logic [TIME_W-1:0] tap_mem [RING_DEPTH];
  logic [TIME_W-1:0] rd_q;

  logic [TIME_W-1:0] gap;
  logic              has_prev;
  logic              restart;
  logic              too_soon;
  logic              store;
  logic [HEAD_W-1:0] base_head;
  logic [CNT_W-1:0]  base_cnt;
  logic [HEAD_W-1:0] head_inc;
  logic [CNT_W-1:0]  cnt_inc;
  logic [HEAD_W-1:0] rd_addr;

  always_comb begin
    gap       = now_r - prev_r;
    has_prev  = (cnt_r != '0);
    restart   = has_prev && (gap > {{(TIME_W-GAP_W){1'b0}}, cfg.restart_gap});
    too_soon  = has_prev && !restart && (gap < {{(TIME_W-GAP_W){1'b0}}, cfg.min_gap});
    base_head = restart ? '0 : head_r;
    base_cnt  = restart ? '0 : cnt_r;
    head_inc  = (base_head == HEAD_W'(RING_DEPTH - 1)) ? '0 : base_head + HEAD_W'(1);
    cnt_inc   = (base_cnt == CNT_W'(RING_DEPTH)) ? base_cnt : base_cnt + CNT_W'(1);
    rd_addr   = (cnt_inc == CNT_W'(RING_DEPTH)) ? head_inc : '0;
    store     = (state_r == F_CLASS) && !ign_r && !too_soon;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      head_r  <= '0;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid) state_r <= F_CLASS;
        end
        F_CLASS: begin
          if (ign_r || too_soon) begin
            state_r <= F_PUSH;
          end else begin
            head_r  <= head_inc;
            cnt_r   <= cnt_inc;
            state_r <= (cnt_inc < CNT_W'(2)) ? F_PUSH : F_READ;
          end
        end
        F_READ: state_r <= F_PUSH;
        F_PUSH: begin
          if (!q_full) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          now_r <= in_time;
          ign_r <= in_ign;
        end
      end
      F_CLASS: begin
        job_r.span    <= '0;
        job_r.divisor <= DIV_W'(cnt_inc - CNT_W'(1));
        job_r.compute <= 1'b0;
        if (ign_r) begin
          job_r.status <= ST_IGNORED;
        end else if (too_soon) begin
          job_r.status <= ST_TOO_SOON;
        end else begin
          prev_r <= now_r;
          if (cnt_inc < CNT_W'(2)) begin
            job_r.status <= ST_NEED_MORE;
          end else begin
            job_r.status  <= ST_UPDATED;
            job_r.compute <= 1'b1;
          end
        end
      end
      F_READ: job_r.span <= now_r - rd_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (store) tap_mem[base_head] <= now_r;
    if (state_r == F_CLASS) rd_q <= tap_mem[rd_addr];
  end

  assign in_ready = (state_r == F_IDLE);
  assign q_push   = (state_r == F_PUSH) && !q_full;
  assign q_job    = job_r;

endmodule

`default_nettype wire

>>> hw/rtl/tte_fifo.sv
// Two-entry job queue between the front end and the back end.
`default_nettype none

module tte_fifo (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  tte_pkg::tte_job_t  push_job,
  output logic               full,
  input  wire                pop,
  output tte_pkg::tte_job_t  pop_job,
  output logic               empty
);
  import tte_pkg::*;

  localparam int AW    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tte_job_t         ent_r [QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_job;
  end

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = ent_r[rd_ptr_r];

endmodule

`default_nettype wire

>>> hw/rtl/tte_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module tte_div (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  input  wire  [tte_pkg::QUO_W-1:0] num,
  input  wire  [tte_pkg::QUO_W-1:0] den,
  output logic                      done,
  output logic [tte_pkg::QUO_W-1:0] quo
);
  import tte_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [QUO_W-1:0]  rem_r;
  logic [QUO_W-1:0]  quo_r;
  logic [QUO_W-1:0]  den_r;

  logic [QUO_W:0]    shifted;
  logic [QUO_W:0]    trial;

  always_comb begin
    shifted = {rem_r, quo_r[QUO_W-1]};
    trial   = shifted - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DIV_STEPS);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      if (!trial[QUO_W]) begin
        rem_r <= trial[QUO_W-1:0];
        quo_r <= {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[QUO_W-1:0];
        quo_r <= {quo_r[QUO_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

>>> hw/rtl/tte_back.sv
// Back end: averages the tap span, derives the tempo and holds the result.
`default_nettype none

module tte_back (
  input  wire                          clk,
  input  wire                          rst_n,
  input  tte_pkg::tte_cfg_t            cfg,
  input  wire                          q_empty,
  input  tte_pkg::tte_job_t            q_job,
  output logic                         q_pop,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [tte_pkg::STATUS_W-1:0] out_status,
  output logic [tte_pkg::BPM_W-1:0]    out_bpm
);
  import tte_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_DIV1 = 4'b0010,
    B_DIV2 = 4'b0100,
    B_OUT  = 4'b1000
  } back_state_t;

  back_state_t      state_r;
  tte_status_t      res_status_r;
  logic [BPM_W-1:0] res_bpm_r;

  logic                  div_start;
  logic [QUO_W-1:0]      div_num;
  logic [QUO_W-1:0]      div_den;
  logic                  div_done;
  logic [QUO_W-1:0]      div_quo;
  logic [TIME_W-1:0]     avg;
  logic [BPM_CALC_W-1:0] bpm;
  logic                  in_range;

  tte_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    avg      = div_quo[TIME_W-1:0];
    bpm      = div_quo[BPM_CALC_W-1:0];
    in_range = (bpm >= BPM_CALC_W'(cfg.bpm_low)) && (bpm <= BPM_CALC_W'(cfg.bpm_high));
    q_pop    = (state_r == B_IDLE) && !q_empty;
    div_start = 1'b0;
    div_num   = {1'b0, q_job.span};
    div_den   = QUO_W'(q_job.divisor);
    case (state_r)
      B_IDLE: div_start = q_pop && q_job.compute;
      B_DIV1: begin
        div_start = div_done && (avg != '0);
        div_num   = TEMPO_NUM + {1'b0, avg};
        div_den   = {avg, 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (!q_empty) state_r <= q_job.compute ? B_DIV1 : B_OUT;
        end
        B_DIV1: begin
          if (div_done) state_r <= (avg == '0) ? B_OUT : B_DIV2;
        end
        B_DIV2: begin
          if (div_done) state_r <= B_OUT;
        end
        B_OUT: begin
          if (out_ready) state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        res_status_r <= q_job.status;
        res_bpm_r    <= '0;
      end
      B_DIV1: begin
        if (div_done && (avg == '0)) res_status_r <= ST_OUT_RANGE;
      end
      B_DIV2: begin
        if (div_done) begin
          if (in_range) begin
            res_status_r <= ST_UPDATED;
            res_bpm_r    <= bpm[BPM_W-1:0];
          end else begin
            res_status_r <= ST_OUT_RANGE;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid  = (state_r == B_OUT);
  assign out_status = res_status_r;
  assign out_bpm    = res_bpm_r;

endmodule

`default_nettype wire
